FILE: hw/rtl/stmd_pkg.sv
// Shared types, codes, sizes and the glyph font for the scrolling text matrix driver.
`timescale 1ns / 1ps
`default_nettype none
package stmd_pkg;

  // Default size of the text store, in characters
  localparam int TEXT_DEPTH_DEFAULT = 64;

  // Field widths of the channels
  localparam int OP_W        = 1;
  localparam int CHAR_IDX_W  = 6;
  localparam int GLYPH_W     = 5;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 5;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int TEXT_LEN_W  = 7;
  localparam int FRAME_CNT_W = 16;
  localparam int SHIFT_W     = 3;

  // Item operations
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_LENGTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_STEP = 8'd1;

  // Reset values of the configuration registers
  localparam logic [TEXT_LEN_W-1:0]  TEXT_LENGTH_RESET     = 7'd1;
  localparam logic [FRAME_CNT_W-1:0] FRAMES_PER_STEP_RESET = 16'd3500;

  // Scan geometry: rows run from ROW_LAST down to row 0
  localparam int                 NUM_ROWS   = 5;
  localparam logic [ROW_W-1:0]   ROW_LAST   = 3'd4;
  localparam logic [ROW_W-1:0]   ROW_FIRST  = 3'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_LAST = 3'd4;
  localparam logic [SHIFT_W-1:0] GLYPH_COLS = 3'd5;

  localparam int                 NUM_GLYPHS = 28;
  localparam logic [GLYPH_W-1:0] GLYPH_MAX  = 5'd27;

  // Font: one 5-bit row pattern per glyph row, bit 0 is the leftmost column
  localparam logic [COL_W-1:0] FONT [NUM_GLYPHS][NUM_ROWS] = '{
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00},  // space
    '{5'h11, 5'h11, 5'h00, 5'h11, 5'h0E},  // smiley
    '{5'h04, 5'h0A, 5'h0A, 5'h0E, 5'h0A},  // A
    '{5'h0E, 5'h0A, 5'h06, 5'h0A, 5'h0E},  // B
    '{5'h0E, 5'h02, 5'h02, 5'h02, 5'h0E},  // C
    '{5'h06, 5'h0A, 5'h0A, 5'h0A, 5'h06},  // D
    '{5'h0E, 5'h02, 5'h06, 5'h02, 5'h0E},  // E
    '{5'h0E, 5'h02, 5'h06, 5'h02, 5'h02},  // F
    '{5'h0E, 5'h02, 5'h0A, 5'h0A, 5'h0E},  // G
    '{5'h0A, 5'h0A, 5'h0E, 5'h0A, 5'h0A},  // H
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E},  // I
    '{5'h08, 5'h08, 5'h08, 5'h0A, 5'h0E},  // J
    '{5'h0A, 5'h0A, 5'h06, 5'h0A, 5'h0A},  // K
    '{5'h02, 5'h02, 5'h02, 5'h02, 5'h0E},  // L
    '{5'h0A, 5'h0E, 5'h0E, 5'h0A, 5'h0A},  // M
    '{5'h02, 5'h0E, 5'h0A, 5'h0A, 5'h0A},  // N
    '{5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E},  // O
    '{5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h02},  // P
    '{5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0F},  // Q
    '{5'h0E, 5'h0A, 5'h06, 5'h0A, 5'h0A},  // R
    '{5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E},  // S
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04},  // T
    '{5'h0A, 5'h0A, 5'h0A, 5'h0A, 5'h0E},  // U
    '{5'h0A, 5'h0A, 5'h0A, 5'h0A, 5'h04},  // V
    '{5'h11, 5'h11, 5'h11, 5'h04, 5'h0A},  // W
    '{5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A},  // X
    '{5'h0A, 5'h0A, 5'h04, 5'h04, 5'h04},  // Y
    '{5'h0E, 5'h08, 5'h04, 5'h02, 5'h0E}   // Z
  };

  // Glyph codes fetched ahead from the text store for the next frame rebuild
  typedef struct packed {
    logic [GLYPH_W-1:0] left_code;
    logic [GLYPH_W-1:0] right_code;
    logic               fresh;
  } stmd_glyph_pair_t;

  // Row pattern of a glyph; unknown codes draw blank
  function automatic logic [COL_W-1:0] font_row(input logic [GLYPH_W-1:0] code,
                                                input logic [ROW_W-1:0]   row);
    logic [COL_W-1:0] pattern;
    pattern = '0;
    if ((code <= GLYPH_MAX) && (row <= ROW_LAST)) begin
      pattern = FONT[code][row];
    end
    return pattern;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/stmd_if.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface stmd_in_if;
  import stmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [CHAR_IDX_W-1:0] char_index;
  logic [GLYPH_W-1:0]    glyph_code;
  modport source (output valid, output op, output char_index, output glyph_code,
                  input ready);
  modport sink   (input valid, input op, input char_index, input glyph_code,
                  output ready);
endinterface

interface stmd_out_if;
  import stmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] column_drive;
  modport source (output valid, output row_index, output column_drive, input ready);
  modport sink   (input valid, input row_index, input column_drive, output ready);
endinterface

interface stmd_cfg_if;
  import stmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/stmd_text_mem.sv
// Text store RAM with a registered prefetch of the two glyph codes of the next rebuild.
`timescale 1ns / 1ps
`default_nettype none
module stmd_text_mem
  import stmd_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [CHAR_IDX_W-1:0]         wr_index,
  input  wire logic [GLYPH_W-1:0]            wr_code,
  input  wire logic [$clog2(TEXT_DEPTH)-1:0] left_addr,
  input  wire logic [$clog2(TEXT_DEPTH)-1:0] right_addr,
  output stmd_glyph_pair_t                   glyphs
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int XW = (AW > CHAR_IDX_W) ? AW : CHAR_IDX_W;

  logic [GLYPH_W-1:0] text_ram [TEXT_DEPTH];
  logic [XW-1:0]      wr_index_x;
  logic [AW-1:0]      wr_addr;
  logic               wr_hit;
  logic [GLYPH_W-1:0] left_code;
  logic [GLYPH_W-1:0] right_code;
  logic [AW-1:0]      left_rd_addr;
  logic [AW-1:0]      right_rd_addr;

  // Drop writes beyond the store
  assign wr_index_x = XW'(wr_index);
  assign wr_addr    = wr_index_x[AW-1:0];
  assign wr_hit     = wr_en && (int'(wr_index) < TEXT_DEPTH);

  // Write port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      text_ram[wr_addr] <= wr_code;
    end
  end

  // Read both codes every cycle, forwarding a write to the same entry
  always_ff @(posedge clk) begin
    left_code  <= (wr_hit && (wr_addr == left_addr))  ? wr_code : text_ram[left_addr];
    right_code <= (wr_hit && (wr_addr == right_addr)) ? wr_code : text_ram[right_addr];
  end

  // Track which addresses the read data belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      left_rd_addr  <= '0;
      right_rd_addr <= '0;
    end else begin
      left_rd_addr  <= left_addr;
      right_rd_addr <= right_addr;
    end
  end

  assign glyphs.left_code  = left_code;
  assign glyphs.right_code = right_code;
  assign glyphs.fresh      = (left_rd_addr == left_addr) && (right_rd_addr == right_addr);

endmodule
`default_nettype wire

FILE: hw/rtl/stmd_scan.sv
// Row scan, frame counter, scroll position, frame buffer rebuild and result register.
`timescale 1ns / 1ps
`default_nettype none
module stmd_scan
  import stmd_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  stmd_in_if.sink                                   in_ch,
  stmd_out_if.source                                out_ch,
  input  wire logic [((($clog2(TEXT_DEPTH + 1)) > TEXT_LEN_W) ?
                      ($clog2(TEXT_DEPTH + 1)) : TEXT_LEN_W)-1:0] eff_length,
  input  wire logic [FRAME_CNT_W-1:0]               frame_limit,
  input  wire stmd_glyph_pair_t                     glyphs,
  output logic [$clog2(TEXT_DEPTH)-1:0]             left_addr,
  output logic [$clog2(TEXT_DEPTH)-1:0]             right_addr
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int LW = $clog2(TEXT_DEPTH + 1);
  localparam int CW = (LW > TEXT_LEN_W) ? LW : TEXT_LEN_W;

  logic [ROW_W-1:0]       scan_row;
  logic [FRAME_CNT_W-1:0] frame_count;
  logic [AW-1:0]          scroll_char_pos;
  logic [SHIFT_W-1:0]     scroll_shift;
  logic [COL_W-1:0]       frame_rows [NUM_ROWS];
  logic [COL_W-1:0]       frame_rows_next [NUM_ROWS];

  logic                   out_valid;
  logic [ROW_W-1:0]       out_row;
  logic [COL_W-1:0]       out_col;

  logic                   out_free;
  logic                   in_accept;
  logic                   tick;
  logic                   frame_end;
  logic [FRAME_CNT_W-1:0] frame_count_inc;
  logic                   rebuild;
  logic                   pos_ok;
  logic [AW-1:0]          left_pos;
  logic [CW-1:0]          left_inc;
  logic [AW-1:0]          right_pos;
  logic [SHIFT_W-1:0]     shift_eff;

  // Handshake: the result register frees the input side; a row-0 item waits for the prefetch
  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = out_free && (glyphs.fresh || (scan_row != ROW_FIRST));
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign tick        = in_accept && (in_ch.op == OP_TICK);

  // Frame counting at the end of each full scan
  assign frame_end       = tick && (scan_row == ROW_FIRST);
  assign frame_count_inc = frame_count + 1'b1;
  assign rebuild         = frame_end && (frame_count_inc >= frame_limit);

  // Scroll position, restarting when the text has shrunk below it
  assign pos_ok     = CW'(scroll_char_pos) < eff_length;
  assign left_pos   = pos_ok ? scroll_char_pos : '0;
  assign shift_eff  = pos_ok ? scroll_shift : '0;
  assign left_inc   = CW'(left_pos) + 1'b1;
  assign right_pos  = (left_inc >= eff_length) ? '0 : left_inc[AW-1:0];
  assign left_addr  = left_pos;
  assign right_addr = right_pos;

  // Compose each frame row from the two neighboring glyphs
  always_comb begin
    logic [2*COL_W-1:0] left_bits;
    logic [2*COL_W-1:0] right_bits;
    logic [2*COL_W-1:0] merged;
    for (int r = 0; r < NUM_ROWS; r++) begin
      left_bits  = {{COL_W{1'b0}}, font_row(glyphs.left_code, ROW_W'(r))};
      right_bits = {{COL_W{1'b0}}, font_row(glyphs.right_code, ROW_W'(r))};
      merged     = (left_bits >> shift_eff) | (right_bits << (GLYPH_COLS - shift_eff));
      frame_rows_next[r] = merged[COL_W-1:0];
    end
  end

  // Scan, frame and scroll state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row        <= ROW_LAST;
      frame_count     <= '0;
      scroll_char_pos <= '0;
      scroll_shift    <= '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        frame_rows[r] <= '0;
      end
    end else if (tick) begin
      if (scan_row == ROW_FIRST) begin
        scan_row <= ROW_LAST;
      end else begin
        scan_row <= scan_row - 1'b1;
      end
      if (frame_end) begin
        frame_count <= rebuild ? '0 : frame_count_inc;
      end
      if (rebuild) begin
        frame_rows <= frame_rows_next;
        if (shift_eff == SHIFT_LAST) begin
          scroll_shift    <= '0;
          scroll_char_pos <= right_pos;
        end else begin
          scroll_shift    <= shift_eff + 1'b1;
          scroll_char_pos <= left_pos;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_row <= scan_row;
      out_col <= ~frame_rows[scan_row];
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.row_index    = out_row;
  assign out_ch.column_drive = out_col;

`ifndef SYNTH
  // A result never gets overwritten while it still waits
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ch.ready |-> !tick)
    else $error("stmd_scan: tick taken while result stalled");

  // A full scan wraps back to the last row
  assert property (@(posedge clk) disable iff (rst) frame_end |=> scan_row == ROW_LAST)
    else $error("stmd_scan: scan did not wrap after row 0");

  // A rebuild only uses glyph codes fetched for the current position
  assert property (@(posedge clk) disable iff (rst) rebuild |-> glyphs.fresh)
    else $error("stmd_scan: rebuild with stale glyph codes");

  // Column shift stays inside one glyph
  assert property (@(posedge clk) disable iff (rst) scroll_shift <= SHIFT_LAST)
    else $error("stmd_scan: scroll shift out of range");

  // Each accepted tick yields a result on the next cycle
  assert property (@(posedge clk) disable iff (rst) tick |=> out_valid)
    else $error("stmd_scan: tick produced no result");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/scrolling_text_matrix_driver_top.sv
// Top level of the scrolling text matrix driver: configuration registers and wiring.
`timescale 1ns / 1ps
`default_nettype none
// Drives a 5x5 LED matrix with a scrolling circular text. A write item (op 0) stores
// a glyph code in the text RAM and returns nothing; a tick item (op 1) scans one row,
// 4 down to 0, and returns that row's active-low column pattern. After frames_per_step
// full frames the frame buffer is rebuilt at the current scroll position, which then
// moves one column. A tick's result sits in the output register the cycle after the
// tick is taken, and one transaction is taken per clock while the result side keeps
// up. The input holds while a result waits in the output register with out_ch.ready
// low. Apart from that, the only hold is on any item offered while row 0 is next, right
// after a text_length write that moves the read addresses, while the two glyph codes are
// fetched again from the text RAM's registered read ports. The text RAM is not cleared:
// write every character of the text before the first scroll step reads it.
module scrolling_text_matrix_driver_top
  import stmd_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  stmd_in_if.sink     in_ch,
  stmd_out_if.source  out_ch,
  stmd_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int LW = $clog2(TEXT_DEPTH + 1);
  localparam int CW = (LW > TEXT_LEN_W) ? LW : TEXT_LEN_W;

  logic [TEXT_LEN_W-1:0]  text_length;
  logic [FRAME_CNT_W-1:0] frames_per_step;
  logic                   cfg_write;
  logic [CW-1:0]          length_x;
  logic [CW-1:0]          eff_length;
  logic [FRAME_CNT_W-1:0] frame_limit;
  logic                   text_write;
  logic [AW-1:0]          left_addr;
  logic [AW-1:0]          right_addr;
  stmd_glyph_pair_t       glyphs;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length     <= TEXT_LENGTH_RESET;
      frames_per_step <= FRAMES_PER_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_ch.index)
        REG_TEXT_LENGTH:     text_length     <= cfg_ch.data[TEXT_LEN_W-1:0];
        REG_FRAMES_PER_STEP: frames_per_step <= cfg_ch.data[FRAME_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to 1..TEXT_DEPTH and the step period to at least one frame
  assign length_x    = CW'(text_length);
  assign eff_length  = (length_x == '0) ? CW'(1) :
                       (length_x > CW'(TEXT_DEPTH)) ? CW'(TEXT_DEPTH) : length_x;
  assign frame_limit = (frames_per_step == '0) ? FRAME_CNT_W'(1) : frames_per_step;

  // Character writes go straight to the text RAM
  assign text_write = in_ch.valid && in_ch.ready && (in_ch.op == OP_WRITE);

  stmd_text_mem #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_text_mem (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (text_write),
    .wr_index   (in_ch.char_index),
    .wr_code    (in_ch.glyph_code),
    .left_addr  (left_addr),
    .right_addr (right_addr),
    .glyphs     (glyphs)
  );

  stmd_scan #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .eff_length  (eff_length),
    .frame_limit (frame_limit),
    .glyphs      (glyphs),
    .left_addr   (left_addr),
    .right_addr  (right_addr)
  );

endmodule
`default_nettype wire
